FILE: hw/rtl/cecf_pkg.sv
// Package for the circle edge cut finder: widths, register indexes, sequencer states.
// No dependencies.
package cecf_pkg;

  localparam int FracBits = 16;
  localparam int FracW    = 17;
  localparam logic [FracW-1:0] FracMax = {FracW{1'b1}};

  // configuration register indexes
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegRadius  = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StSqr,
    StRoot,
    StDiv,
    StOut
  } state_e;

endpackage

FILE: hw/rtl/cecf_sqrt.sv
// Iterative truncated square root of a 65-bit value, one result bit per cycle.
// Depends on nothing.
module cecf_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [64:0] rad_i,
  output logic        done_o,
  output logic [32:0] root_o
);

  logic [64:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic [66:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [66:0] trial;
  logic [66:0] shifted;

  // restoring digit-by-digit: bring in two radicand bits, try 4*root+1
  always_comb begin
    rem_d   = rem_q;
    root_d  = root_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {acc_q[64:0], rem_q[64:63]};
    trial   = {root_q, 2'b01};
    if (start_i) begin
      rem_d  = {rad_i[63:0], 1'b0};
      acc_d  = {66'd0, rad_i[64]};
      root_d = '0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
      // top bit handled first as a single-bit step
      if (rad_i[64]) begin
        acc_d  = '0;
        root_d = 33'd1;
      end
    end else if (busy_q) begin
      rem_d = {rem_q[62:0], 2'b00};
      if (shifted >= trial) begin
        acc_d  = shifted - trial;
        root_d = {root_q[31:0], 1'b1};
      end else begin
        acc_d  = shifted;
        root_d = {root_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    acc_q  <= acc_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd31);
  assign root_o = root_d;

endmodule

FILE: hw/rtl/circle_edge_cut_finder.sv
// Circle edge cut finder: one edge beat in, one result beat out.
// Per endpoint the squares are summed by shift-add and the root is taken; cut edges
// then run the restoring divider, and every edge ends in the output state. in_ready_o
// is low while an edge is at work, so a new edge is taken only once the last one is
// through. The output register frees once the result beat is taken.
// Reset: asynchronous active low; centre 0, radius 1.0, element OR cleared.
// Depends on cecf_pkg and cecf_sqrt.
module circle_edge_cut_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic [31:0] start_node_i,
  input  logic [31:0] end_node_i,
  input  logic [3:0]  side_index_i,
  input  logic        last_side_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        edge_cut_o,
  output logic [16:0] cut_fraction_o,
  output logic [31:0] cut_start_node_o,
  output logic [31:0] cut_end_node_o,
  output logic [3:0]  cut_side_o,
  output logic        element_cut_o,
  output logic        element_done_o
);

  localparam int QW    = 34 + cecf_pkg::FracBits;
  // quotient bits: |a| / (|a| + |b|) stays below one
  localparam int QBits = cecf_pkg::FracBits + 1;

  cecf_pkg::state_e state_q, state_d;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0] rad_q;
  logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
  logic [31:0] sn_q, en_q;
  logic [3:0]  side_q;
  logic        last_q;
  logic        acc_q, acc_d;
  logic        pt_q, pt_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] mx_q, my_q, mx_d, my_d;
  logic [64:0] sum_q, sum_d;
  logic signed [34:0] la_q, la_d, lb_q, lb_d;
  logic [QW-1:0] num_q, num_d;
  logic [34:0]   den_q, den_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [35:0]   prem_q, prem_d;
  logic        cut_q, cut_d;
  logic [16:0] frac_d;
  logic        sq_start, sq_done;
  logic [32:0] root;
  logic [32:0] dx_m, dy_m;
  logic signed [32:0] dx, dy;
  logic signed [34:0] lvl;
  logic [35:0] ptry;
  logic [34:0] ma, mb;
  logic [QW-1:0] num_init;

  // multiplicand times a two-bit slice of the multiplier
  function automatic logic [64:0] pair_term(input logic [32:0] m, input logic [1:0] b);
    logic [64:0] t;
    t = '0;
    if (b[0]) t = t + {32'd0, m};
    if (b[1]) t = t + {31'd0, m, 1'b0};
    return t;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cecf_pkg::RegCenterX: cx_q  <= cfg_data_i;
        cecf_pkg::RegCenterY: cy_q  <= cfg_data_i;
        cecf_pkg::RegRadius:  rad_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // edge capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sx_q <= start_x_i; sy_q <= start_y_i;
      ex_q <= end_x_i;   ey_q <= end_y_i;
      sn_q <= start_node_i; en_q <= end_node_i;
      side_q <= side_index_i; last_q <= last_side_i;
    end
  end

  // differences to the centre for the current endpoint
  assign dx   = pt_q ? ({ex_q[31], ex_q} - {cx_q[31], cx_q})
                     : ({sx_q[31], sx_q} - {cx_q[31], cx_q});
  assign dy   = pt_q ? ({ey_q[31], ey_q} - {cy_q[31], cy_q})
                     : ({sy_q[31], sy_q} - {cy_q[31], cy_q});
  assign dx_m = dx[32] ? 33'(-dx) : 33'(dx);
  assign dy_m = dy[32] ? 33'(-dy) : 33'(dy);
  assign lvl  = $signed({2'b00, root}) - $signed({4'b0000, rad_q});
  assign ma   = la_q[34] ? 35'(-la_q) : 35'(la_q);
  assign mb   = lb_d[34] ? 35'(-lb_d) : 35'(lb_d);
  assign num_init = QW'(ma) << cecf_pkg::FracBits;
  assign ptry = {prem_q[34:0], num_q[QW-1]} - {1'b0, den_q};
  assign sq_start = (state_q == cecf_pkg::StSqr) && (cnt_q == 5'd16);

  // root unit takes the finished sum in the cycle it is formed
  cecf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sum_d),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // sequencer: shift-add squaring, shared root, restoring divide
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; pt_d = pt_q; acc_d = acc_q;
    mx_d = mx_q; my_d = my_q; sum_d = sum_q;
    la_d = la_q; lb_d = lb_q;
    num_d = num_q; den_d = den_q; quo_d = quo_q; prem_d = prem_q;
    cut_d = cut_q;
    frac_d = (|(quo_q >> cecf_pkg::FracW)) ? cecf_pkg::FracMax
                                           : quo_q[cecf_pkg::FracW-1:0];
    unique case (state_q)
      cecf_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = cecf_pkg::StSqr;
          cnt_d = '0; pt_d = 1'b0;
        end
      end
      cecf_pkg::StSqr: begin
        // two multiplier bits of each square per cycle
        if (cnt_q == 5'd0) begin
          mx_d = dx_m; my_d = dy_m; sum_d = '0;
          cnt_d = 5'd1;
        end else if (cnt_q < 5'd16) begin
          sum_d = sum_q
                + (pair_term(dx_m, mx_q[1:0]) << {cnt_q - 5'd1, 1'b0})
                + (pair_term(dy_m, my_q[1:0]) << {cnt_q - 5'd1, 1'b0});
          mx_d = mx_q >> 2; my_d = my_q >> 2;
          cnt_d = cnt_q + 5'd1;
        end else begin
          // last pair plus the top bit, then launch the root
          sum_d = sum_q
                + (pair_term(dx_m, mx_q[1:0]) << 30)
                + (pair_term(dy_m, my_q[1:0]) << 30)
                + (mx_q[2] ? {dx_m, 32'd0} : 65'd0)
                + (my_q[2] ? {dy_m, 32'd0} : 65'd0);
          state_d = cecf_pkg::StRoot;
        end
      end
      cecf_pkg::StRoot: begin
        if (sq_done) begin
          if (!pt_q) begin
            la_d = lvl; pt_d = 1'b1; cnt_d = '0;
            state_d = cecf_pkg::StSqr;
          end else begin
            lb_d = lvl;
            cut_d = (la_q[34] && !lvl[34] && lvl != 0)
                 || (lvl[34] && !la_q[34] && la_q != 0);
            // high numerator bits preload the remainder, they stay below the divisor
            num_d = num_init << (QW - QBits);
            den_d = ma + mb;
            quo_d = '0; prem_d = 36'(num_init >> QBits); cnt_d = '0;
            state_d = cut_d ? cecf_pkg::StDiv : cecf_pkg::StOut;
          end
        end
      end
      cecf_pkg::StDiv: begin
        // one quotient bit per cycle, top bits of the numerator first
        num_d = num_q << 1;
        if (!ptry[35]) begin
          prem_d = ptry;
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          prem_d = {prem_q[34:0], num_q[QW-1]};
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(QBits - 1)) state_d = cecf_pkg::StOut;
      end
      cecf_pkg::StOut: begin
        if (!out_valid_o || out_ready_i) begin
          acc_d = last_q ? 1'b0 : (acc_q | cut_q);
          state_d = cecf_pkg::StIdle;
        end
      end
      default: state_d = cecf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cecf_pkg::StIdle;
      acc_q <= 1'b0; cnt_q <= '0; pt_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d; cnt_q <= cnt_d; pt_q <= pt_d;
      if (state_q == cecf_pkg::StOut && (!out_valid_o || out_ready_i))
        out_valid_o <= 1'b1;
      else if (out_ready_i)
        out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d; my_q <= my_d; sum_q <= sum_d;
    la_q <= la_d; lb_q <= lb_d;
    num_q <= num_d; den_q <= den_d; quo_q <= quo_d; prem_q <= prem_d;
    cut_q <= cut_d;
    if (state_q == cecf_pkg::StOut && (!out_valid_o || out_ready_i)) begin
      edge_cut_o <= cut_q;
      cut_fraction_o <= cut_q ? frac_d : 17'd0;
      cut_start_node_o <= sn_q;
      cut_end_node_o <= en_q;
      cut_side_o <= side_q;
      element_cut_o <= acc_q | cut_q;
      element_done_o <= last_q;
    end
  end

  assign in_ready_o = (state_q == cecf_pkg::StIdle);

  // checks
  a_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !edge_cut_o |-> cut_fraction_o == 17'd0)
    else $error("fraction set on an uncut edge");
  a_elem_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_cut_o |-> element_cut_o)
    else $error("element flag misses an edge cut");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new beat taken while busy");

endmodule
